[hdl/jpeg_end_of_image_finder_macros.svh]
// assertion macros for the jpeg end-of-image finder checker
`ifndef JPEG_END_OF_IMAGE_FINDER_MACROS_SVH
`define JPEG_END_OF_IMAGE_FINDER_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define JEOI_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("jeoi check failed");

// next-cycle implication, sampled on clk, off while arst_n is low
`define JEOI_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("jeoi check failed");

`endif

[hdl/jeoi_pkg.sv]
// types and constants for the jpeg end-of-image finder
package jeoi_pkg;

	localparam int unsigned LENGTH_BITS = 32;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_GOT_FF = 3'd1,
		PH_LEN_HI = 3'd2,
		PH_LEN_LO = 3'd3,
		PH_SKIP   = 3'd4,
		PH_DONE   = 3'd5
	} phase_t;

	localparam logic [1:0] ST_EOI   = 2'd0;
	localparam logic [1:0] ST_BOGUS = 2'd1;
	localparam logic [1:0] ST_ENDED = 2'd2;

	localparam logic [7:0] B_FF   = 8'hFF;
	localparam logic [7:0] B_00   = 8'h00;
	localparam logic [7:0] B_80   = 8'h80;
	localparam logic [7:0] B_EOI  = 8'hD9;
	localparam logic [7:0] B_JLS  = 8'hF7;
	localparam logic [7:0] B_SOS  = 8'hDA;
	localparam logic [7:0] B_RST0 = 8'hD0;
	localparam logic [7:0] B_RST7 = 8'hD7;
	localparam logic [7:0] B_TEM  = 8'h01;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       first_byte;
		logic       last_byte;
	} byte_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] image_length;
		logic        jpegls_found;
	} result_item_t;

endpackage

[hdl/jpeg_end_of_image_finder.sv]
// jpeg end-of-image finder: walks markers of a byte stream, one result per candidate
//
// channel   dir  handshake                    payload
// byte      in   byte_valid / byte_stall      byte_item (data_byte, first_byte, last_byte)
// result    out  result_valid / result_stall  result_item (status, image_length, jpegls_found)
//
// one byte per cycle while byte_stall is low; a byte is captured in the input register, and its result,
// if any, is registered in the result register when that byte is processed
// the marker walk is a single state update per byte between those two registers
// reset clears all control state and empties both registers
// a stalled result holds the input register; bytes keep flowing while the result
// register is empty or being taken
module jpeg_end_of_image_finder (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  byte_valid,
	output logic                  byte_stall,
	input  jeoi_pkg::byte_item_t  byte_item,
	output logic                  result_valid,
	input  logic                  result_stall,
	output jeoi_pkg::result_item_t result_item
);
	import jeoi_pkg::*;

	localparam int unsigned CountW = LENGTH_BITS;
	localparam int unsigned WideW  = (CountW > 32) ? CountW : 33;
	localparam logic [CountW-1:0] CountMax = '1;

	byte_item_t   item_s1;
	logic         valid_s1;
	result_item_t result_q;
	logic         result_valid_q;

	phase_t            phase_q;
	logic              in_scan_q;
	logic              jls_q;
	logic [CountW-1:0] count_q;
	logic [15:0]       skip_q;
	logic [7:0]        len_hi_q;

	phase_t            phase_d;
	logic              in_scan_d;
	logic              jls_d;
	logic [CountW-1:0] count_d;
	logic [15:0]       skip_d;
	logic [7:0]        len_hi_d;

	logic              emit;
	logic [1:0]        emit_status;
	logic              emit_len;
	logic              proc;
	logic              take_in;
	logic [7:0]        b;
	logic [15:0]       seg;
	logic [WideW-1:0]  count_wide;
	logic [31:0]       count_sat;
	logic              is_rst;

	assign proc    = valid_s1 && !(result_valid_q && result_stall);
	assign take_in = !valid_s1 || proc;
	assign byte_stall = !take_in;

	assign b      = item_s1.data_byte;
	assign seg    = {len_hi_q, b};
	assign is_rst = (b >= B_RST0) && (b <= B_RST7);

	always_comb begin
		phase_d     = phase_q;
		in_scan_d   = in_scan_q;
		jls_d       = jls_q;
		count_d     = count_q;
		skip_d      = skip_q;
		len_hi_d    = len_hi_q;
		emit        = 1'b0;
		emit_status = ST_ENDED;
		emit_len    = 1'b0;
		if (item_s1.first_byte) begin
			phase_d   = PH_IDLE;
			in_scan_d = 1'b0;
			jls_d     = 1'b0;
			count_d   = '0;
			skip_d    = '0;
			len_hi_d  = '0;
		end
		if (phase_d != PH_DONE && phase_d <= PH_SKIP) begin
			if (count_d != CountMax) begin
				count_d = count_d + 1'b1;
			end
			case (phase_d)
				PH_IDLE: begin
					if (b == B_FF) begin
						phase_d = PH_GOT_FF;
					end
				end
				PH_GOT_FF: begin
					if (b == B_FF) begin
						phase_d = PH_GOT_FF;
					end else if (b == B_00 || (jls_d && b < B_80 && in_scan_d)) begin
						phase_d = PH_IDLE;
					end else if (b == B_EOI) begin
						emit        = 1'b1;
						emit_status = ST_EOI;
						emit_len    = 1'b1;
					end else begin
						if (b == B_JLS) begin
							jls_d = 1'b1;
						end
						if (b == B_SOS) begin
							in_scan_d = 1'b1;
						end else if (!is_rst) begin
							in_scan_d = 1'b0;
						end
						if ((b >= B_RST0 && b <= B_SOS) || b == B_TEM) begin
							phase_d = PH_IDLE;
						end else begin
							phase_d = PH_LEN_HI;
						end
					end
				end
				PH_LEN_HI: begin
					len_hi_d = b;
					phase_d  = PH_LEN_LO;
				end
				PH_LEN_LO: begin
					if (seg < 16'd2) begin
						emit        = 1'b1;
						emit_status = ST_BOGUS;
					end else begin
						skip_d  = seg - 16'd2;
						phase_d = (skip_d == '0) ? PH_IDLE : PH_SKIP;
					end
				end
				PH_SKIP: begin
					if (skip_d != '0) begin
						skip_d = skip_d - 1'b1;
					end
					if (skip_d == '0) begin
						phase_d = PH_IDLE;
					end
				end
				default: begin
					phase_d = PH_DONE;
				end
			endcase
			if (!emit && item_s1.last_byte) begin
				emit        = 1'b1;
				emit_status = ST_ENDED;
			end
			if (emit) begin
				phase_d = PH_DONE;
			end
		end
	end

	assign count_wide = WideW'(count_d);
	assign count_sat  = (count_wide > WideW'(32'hFFFF_FFFF)) ? '1 : count_wide[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			result_valid_q <= 1'b0;
			phase_q        <= PH_IDLE;
			in_scan_q      <= 1'b0;
			jls_q          <= 1'b0;
			count_q        <= '0;
			skip_q         <= '0;
			len_hi_q       <= '0;
		end else begin
			if (take_in) begin
				valid_s1 <= byte_valid;
			end
			if (proc && emit) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
			if (proc) begin
				phase_q   <= phase_d;
				in_scan_q <= in_scan_d;
				jls_q     <= jls_d;
				count_q   <= count_d;
				skip_q    <= skip_d;
				len_hi_q  <= len_hi_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_in && byte_valid) begin
			item_s1 <= byte_item;
		end
		if (proc && emit) begin
			result_q.status       <= emit_status;
			result_q.image_length <= emit_len ? count_sat : 32'd0;
			result_q.jpegls_found <= jls_d;
		end
	end

	assign result_valid = result_valid_q;
	assign result_item  = result_q;

endmodule

[hdl/jeoi_checker.sv]
// port-level checker for the jpeg end-of-image finder, with its bind
`include "jpeg_end_of_image_finder_macros.svh"

module jeoi_checker (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   result_valid,
	input logic                   result_stall,
	input jeoi_pkg::result_item_t result_item
);
	import jeoi_pkg::*;

	logic [1:0]  st;
	logic [31:0] len;

	assign st  = result_item.status;
	assign len = result_item.image_length;

	`JEOI_ASSERT_NEXT(a_result_held, result_valid && result_stall, result_valid)
	`JEOI_ASSERT_NOW(a_status_code, result_valid, st == ST_EOI || st == ST_BOGUS || st == ST_ENDED)
	`JEOI_ASSERT_NOW(a_len_zero, result_valid && st != ST_EOI, len == 32'd0)
	`JEOI_ASSERT_NOW(a_eoi_len_min, result_valid && st == ST_EOI, len >= 32'd2)

endmodule

bind jpeg_end_of_image_finder jeoi_checker u_jeoi_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result_item  (result_item)
);
